// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SBUSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define SBUSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must never hold outside reset.
`define SBUSD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== sv/sbusd_pkg.sv =====
// Types and constants of the S-Bus frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package sbusd_pkg;

	localparam int FRAME_BYTES  = 23;
	localparam int DATA_BYTES   = FRAME_BYTES - 1;
	localparam int DATA_W       = DATA_BYTES * 8;
	localparam int FRAME_W      = FRAME_BYTES * 8;
	localparam int CH_BITS      = 11;
	localparam int N_PROP       = 16;
	localparam int N_RESULTS    = 18;
	localparam int LINK_QUALITY = 255;

	localparam logic [1:0] CFG_HEADER = 2'd0;
	localparam logic [1:0] CFG_FOOTER = 2'd1;
	localparam logic [1:0] CFG_GAP    = 2'd2;
	localparam logic [1:0] CFG_COUNT  = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_FOOTER = 2'd2,
		PH_IGNORE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] footer_byte;
		logic [7:0] gap_ms;
		logic [4:0] channel_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        flags;
		logic [DATA_W-1:0] data;
	} frame_t;

endpackage
`default_nettype wire

// ===== sv/sbusd_front.sv =====
// Front end: gap timing, header search, byte collection and footer check.
`timescale 1ns / 1ps
`default_nettype none
module sbusd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sbusd_pkg::cfg_t cfg,
	input  wire logic            accept,
	input  wire logic            func,
	input  wire logic [7:0]      byte_value,
	input  wire logic            parity_error,
	output logic                 frame_push,
	output sbusd_pkg::frame_t    frame
);
	import sbusd_pkg::*;

	localparam logic [4:0] BC_FULL = 5'(FRAME_BYTES);

	phase_t             phase_q, ph_eff, phase_d;
	logic [4:0]         bc_q, bc_eff, bc_d;
	logic [7:0]         silence_q;
	logic [FRAME_W-1:0] data_q;
	logic               byte_acc, gap_hit, store;

	assign byte_acc = accept && !func;
	assign gap_hit  = silence_q >= cfg.gap_ms;

	always_comb begin
		ph_eff = gap_hit ? PH_HEADER : phase_q;
		bc_eff = gap_hit ? 5'd0 : bc_q;
		if (parity_error) begin
			ph_eff = PH_IGNORE;
		end
		phase_d = ph_eff;
		bc_d    = bc_eff;
		case (ph_eff)
			PH_HEADER: begin
				if (byte_value == cfg.header_byte) begin
					phase_d = PH_DATA;
					bc_d    = 5'd0;
				end else begin
					phase_d = PH_IGNORE;
				end
			end
			PH_DATA: begin
				if (bc_eff < BC_FULL) begin
					bc_d = bc_eff + 5'd1;
				end else begin
					bc_d = BC_FULL;
				end
				if (bc_d >= BC_FULL) begin
					phase_d = PH_FOOTER;
				end
			end
			PH_FOOTER: phase_d = PH_IGNORE;
			default:   phase_d = ph_eff;
		endcase
	end

	always_comb begin
		store      = byte_acc && ph_eff == PH_DATA && bc_eff < BC_FULL;
		frame_push = byte_acc && ph_eff == PH_FOOTER && byte_value == cfg.footer_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			bc_q      <= 5'd0;
			silence_q <= 8'hFF;
		end else if (accept) begin
			if (func) begin
				if (silence_q != 8'hFF) begin
					silence_q <= silence_q + 8'd1;
				end
			end else begin
				silence_q <= 8'd0;
				phase_q   <= phase_d;
				bc_q      <= bc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			data_q <= {byte_value, data_q[FRAME_W-1:8]};
		end
	end

	assign frame = frame_t'(data_q);

endmodule
`default_nettype wire

// ===== sv/sbusd_frame_fifo.sv =====
// Two-entry queue of decoded frames between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module sbusd_frame_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire sbusd_pkg::frame_t wr_frame,
	input  wire logic              rd_en,
	output sbusd_pkg::frame_t      rd_frame,
	output logic                   not_empty,
	output logic                   full,
	output logic [1:0]             level
);
	import sbusd_pkg::*;

	localparam int DEPTH = 2;

	frame_t     mem_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'(DEPTH);
	assign level     = count_q;
	assign rd_frame  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbusd_back.sv =====
// Back end: unpacks one frame into eighteen channel items.
`timescale 1ns / 1ps
`default_nettype none
module sbusd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              frame_valid,
	input  wire sbusd_pkg::frame_t frame,
	output logic                   frame_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [4:0]             channel_index,
	output logic [10:0]            channel_value,
	output logic                   failsafe_flag,
	output logic                   last
);
	import sbusd_pkg::*;

	localparam logic [4:0] CH_LAST = 5'(N_RESULTS - 1);
	localparam logic [4:0] CH_D0   = 5'(N_PROP);

	logic              busy_q, ov_q, slot_free, emit;
	logic [4:0]        ch_q;
	logic [DATA_W-1:0] data_q;
	logic [7:0]        flags_q;
	logic [10:0]       val;

	assign slot_free = !ov_q || pop;
	assign emit      = slot_free && busy_q;
	assign frame_pop = !busy_q && frame_valid;
	assign empty     = !ov_q;

	always_comb begin
		if (ch_q < CH_D0) begin
			val = data_q[CH_BITS-1:0];
		end else if (ch_q == CH_D0) begin
			val = {10'd0, flags_q[0]};
		end else begin
			val = {10'd0, flags_q[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			ch_q   <= 5'd0;
		end else begin
			if (slot_free) begin
				ov_q <= busy_q;
			end
			if (emit) begin
				ch_q <= ch_q + 5'd1;
				if (ch_q == CH_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (frame_pop) begin
				busy_q <= 1'b1;
				ch_q   <= 5'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			channel_index <= ch_q;
			channel_value <= val;
			failsafe_flag <= flags_q[3];
			last          <= ch_q == CH_LAST;
			data_q        <= {{CH_BITS{1'b0}}, data_q[DATA_W-1:CH_BITS]};
		end
		if (frame_pop) begin
			data_q  <= frame.data;
			flags_q <= frame.flags;
		end
	end

endmodule
`default_nettype wire

// ===== sv/sbus_frame_decoder.sv =====
// S-Bus frame decoder top level: configuration registers, front end, frame queue, back end.
//
// Items are received bytes or millisecond ticks. The front end takes one item every cycle
// while full is low and decodes a whole 25-byte frame in place; a frame with a good footer
// enters a two-entry frame queue. The back end takes one frame from the queue at a time and
// delivers its 18 channel items through a single output register at one per cycle while
// that register is free or popped. full is high only while both queue entries hold decoded
// frames that the back end has not yet started.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbus_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic        func,
	input  wire logic [7:0]  byte_value,
	input  wire logic        parity_error,
	input  wire logic        pop,
	output logic             empty,
	output logic [4:0]       channel_index,
	output logic [10:0]      channel_value,
	output logic [4:0]       channel_count_res,
	output logic [7:0]       link_quality,
	output logic             failsafe_flag,
	output logic             last
);
	import sbusd_pkg::*;

	localparam logic [4:0] LAST_INDEX = 5'(N_RESULTS - 1);

	cfg_t       cfg_q;
	frame_t     front_frame, queue_frame;
	logic       accept, frame_push, frame_pop, queue_valid, out_take;
	logic [1:0] queue_level;

	assign accept   = push && !full;
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte   <= 8'h0F;
			cfg_q.footer_byte   <= 8'h00;
			cfg_q.gap_ms        <= 8'd3;
			cfg_q.channel_count <= 5'd18;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEADER: cfg_q.header_byte   <= cfg_data;
				CFG_FOOTER: cfg_q.footer_byte   <= cfg_data;
				CFG_GAP:    cfg_q.gap_ms        <= cfg_data;
				CFG_COUNT:  cfg_q.channel_count <= cfg_data[4:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	sbusd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.func         (func),
		.byte_value   (byte_value),
		.parity_error (parity_error),
		.frame_push   (frame_push),
		.frame        (front_frame)
	);

	sbusd_frame_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (frame_push),
		.wr_frame  (front_frame),
		.rd_en     (frame_pop),
		.rd_frame  (queue_frame),
		.not_empty (queue_valid),
		.full      (full),
		.level     (queue_level)
	);

	sbusd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_valid   (queue_valid),
		.frame         (queue_frame),
		.frame_pop     (frame_pop),
		.pop           (pop),
		.empty         (empty),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.failsafe_flag (failsafe_flag),
		.last          (last)
	);

	assign channel_count_res = cfg_q.channel_count;
	assign link_quality      = 8'(LINK_QUALITY);

	`SBUSD_ASSERT_NEVER(a_queue_overflow, frame_push && full && !frame_pop, "frame queue overflow")
	`SBUSD_ASSERT_NEVER(a_queue_level, queue_level > 2'd2, "frame queue level out of range")
	`SBUSD_ASSERT_IMPL(a_last_index, !empty && last, channel_index == LAST_INDEX, "bad last index")
	`SBUSD_ASSERT_NEXT(a_restart, out_take && last, empty || channel_index == 5'd0, "bad restart")

endmodule
`default_nettype wire

// ===== tb/sbus_frame_decoder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the S-Bus frame decoder: predicts channel items from accepted input items and compares them.
module sbus_frame_decoder_checker
	import sbusd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic        func,
	input  logic [7:0]  byte_value,
	input  logic        parity_error,
	input  logic        pop,
	input  logic        empty,
	input  logic [4:0]  channel_index,
	input  logic [10:0] channel_value,
	input  logic [4:0]  channel_count_res,
	input  logic [7:0]  link_quality,
	input  logic        failsafe_flag,
	input  logic        last,
	output int          failures,
	output int          waiting
);

	typedef struct packed {
		logic [4:0]  index;
		logic [10:0] value;
		logic [4:0]  count;
		logic [7:0]  quality;
		logic        failsafe;
		logic        last;
	} channel_item_t;

	cfg_t          regs;
	phase_t        phase;
	int            byte_count;
	logic [7:0]    frame_bytes [FRAME_BYTES];
	logic [7:0]    silence_ms;
	channel_item_t expected_channels [$];
	channel_item_t got;
	channel_item_t want;

	initial begin
		failures = 0;
		waiting  = 0;
	end

	task automatic decode_item(input logic tick, input logic [7:0] rx, input logic perr);
		logic [FRAME_BYTES*8-1:0] bits;
		logic [7:0]               flags;
		channel_item_t            ch;
		if (tick) begin
			if (silence_ms != 8'hFF)
				silence_ms++;
			return;
		end
		if (silence_ms >= regs.gap_ms) begin
			phase      = PH_HEADER;
			byte_count = 0;
		end
		silence_ms = 8'd0;
		if (perr)
			phase = PH_IGNORE;
		case (phase)
			PH_HEADER: begin
				if (rx != regs.header_byte) begin
					phase = PH_IGNORE;
				end else begin
					byte_count = 0;
					phase      = PH_DATA;
				end
			end
			PH_DATA: begin
				if (byte_count < FRAME_BYTES) begin
					frame_bytes[byte_count] = rx;
					byte_count++;
				end
				if (byte_count >= FRAME_BYTES)
					phase = PH_FOOTER;
			end
			PH_FOOTER: begin
				phase = PH_IGNORE;
				if (rx == regs.footer_byte) begin
					for (int i = 0; i < FRAME_BYTES; i++)
						bits[i*8 +: 8] = frame_bytes[i];
					flags = frame_bytes[FRAME_BYTES-1];
					for (int k = 0; k < N_RESULTS; k++) begin
						ch.index = 5'(k);
						if (k < N_PROP)
							ch.value = bits[k*CH_BITS +: CH_BITS];
						else if (k == N_PROP)
							ch.value = {10'd0, flags[0]};
						else
							ch.value = {10'd0, flags[1]};
						ch.count    = regs.channel_count;
						ch.quality  = 8'(LINK_QUALITY);
						ch.failsafe = flags[3];
						ch.last     = (k == N_RESULTS - 1);
						expected_channels.push_back(ch);
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.header_byte   = 8'h0F;
			regs.footer_byte   = 8'h00;
			regs.gap_ms        = 8'd3;
			regs.channel_count = 5'd18;
			phase              = PH_HEADER;
			byte_count         = 0;
			silence_ms         = 8'hFF;
			expected_channels.delete();
			waiting            = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_HEADER: regs.header_byte   = cfg_data;
					CFG_FOOTER: regs.footer_byte   = cfg_data;
					CFG_GAP:    regs.gap_ms        = cfg_data;
					CFG_COUNT:  regs.channel_count = cfg_data[4:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				got = {channel_index, channel_value, channel_count_res, link_quality,
					failsafe_flag, last};
				if (expected_channels.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected item idx %0d val %0d cnt %0d lq %0d fs %0b last %0b",
							$realtime, got.index, got.value, got.count, got.quality,
							got.failsafe, got.last);
					failures++;
				end else begin
					want = expected_channels.pop_front();
					if (got !== want) begin
						if (failures < 10)
							$display({"%0t: item mismatch: expected idx %0d val %0d cnt %0d lq %0d",
								" fs %0b last %0b, got idx %0d val %0d cnt %0d lq %0d fs %0b last %0b"},
								$realtime, want.index, want.value, want.count, want.quality,
								want.failsafe, want.last, got.index, got.value, got.count,
								got.quality, got.failsafe, got.last);
						failures++;
					end
				end
			end
			if (push && !full)
				decode_item(func, byte_value, parity_error);
			waiting = expected_channels.size();
		end
	end

endmodule

// ===== tb/sbus_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// Top of the S-Bus frame decoder testbench: clock, reset, stimulus, result draining and verdict.
module sbus_frame_decoder_test;
	import sbusd_pkg::*;

	typedef enum int {
		FR_GOOD,
		FR_BAD_HEADER,
		FR_BAD_FOOTER,
		FR_PARITY,
		FR_SHORT,
		FR_NO_GAP,
		FR_MID_GAP
	} frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        push;
	logic        full;
	logic        func;
	logic [7:0]  byte_value;
	logic        parity_error;
	logic        pop;
	logic        empty;
	logic [4:0]  channel_index;
	logic [10:0] channel_value;
	logic [4:0]  channel_count_res;
	logic [7:0]  link_quality;
	logic        failsafe_flag;
	logic        last;
	int          failures;
	int          waiting;

	logic [7:0]  hdr;
	logic [7:0]  ftr;
	int          gap_len;
	int          idle_rate;
	bit          quiet;
	int          stall_left;

	sbus_frame_decoder i_dut (.*);

	sbus_frame_decoder_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("sbus_frame_decoder_test NOT OK");
		$finish;
	end

	initial begin
		pop        = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				stall_left = $urandom_range(1, 14) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic put(input logic tick, input logic [7:0] rx, input logic perr);
		if (!quiet && $urandom_range(0, 9) < idle_rate) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		push         <= 1'b1;
		func         <= tick;
		byte_value   <= rx;
		parity_error <= perr;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) put(1'b1, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_noise(input int n);
		repeat (n) put(1'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	task automatic send_frame(input frame_kind_t kind, input int fill);
		int         err_at;
		logic [7:0] b;
		send_ticks(kind == FR_NO_GAP ? 0 : gap_len + $urandom_range(0, 2));
		err_at = $urandom_range(0, FRAME_BYTES + 1);
		for (int i = 0; i < FRAME_BYTES + 2; i++) begin
			if (kind == FR_SHORT && i == err_at)
				return;
			if (kind == FR_MID_GAP && i == err_at && i > 0)
				send_ticks(gap_len);
			if (i == 0)
				b = (kind == FR_BAD_HEADER) ? hdr ^ 8'($urandom_range(1, 255)) : hdr;
			else if (i == FRAME_BYTES + 1)
				b = (kind == FR_BAD_FOOTER) ? ftr ^ 8'($urandom_range(1, 255)) : ftr;
			else
				b = (fill < 0) ? 8'($urandom) : 8'(fill);
			put(1'b0, b, kind == FR_PARITY && i == err_at);
			if (gap_len > 1 && $urandom_range(0, 11) == 0)
				send_ticks($urandom_range(1, gap_len > 4 ? 3 : gap_len - 1));
		end
	endtask

	task automatic random_frames(input int n);
		int pick;
		int fill;
		idle_rate = $urandom_range(0, 3);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				send_noise($urandom_range(1, 6));
			pick = $urandom_range(0, 11);
			fill = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : -1;
			send_frame(pick < 6 ? FR_GOOD : frame_kind_t'(pick - 5), fill);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic configure(input logic [7:0] h, input logic [7:0] f, input logic [7:0] g,
		input logic [7:0] c);
		write_reg(CFG_HEADER, h);
		write_reg(CFG_FOOTER, f);
		write_reg(CFG_GAP, g);
		write_reg(CFG_COUNT, c);
		cfg_write <= 1'b0;
		hdr     = h;
		ftr     = f;
		gap_len = g;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = CFG_HEADER;
		cfg_data     = 8'd0;
		push         = 1'b0;
		func         = 1'b0;
		byte_value   = 8'd0;
		parity_error = 1'b0;
		quiet        = 1'b0;
		idle_rate    = 2;
		hdr          = 8'h0F;
		ftr          = 8'h00;
		gap_len      = 3;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// widest gap: the saturated silence count re-arms, a frame straight after does not
		write_reg(CFG_GAP, 8'd255);
		cfg_write <= 1'b0;
		gap_len = 255;
		send_ticks(3);
		send_frame(FR_NO_GAP, 255);
		send_frame(FR_NO_GAP, -1);
		settle();

		// reset header, footer and count: an all-zero payload and the broken frame cases
		write_reg(CFG_GAP, 8'd3);
		cfg_write <= 1'b0;
		gap_len = 3;
		send_frame(FR_GOOD, 0);
		send_frame(FR_BAD_HEADER, 8'h5A);
		send_frame(FR_PARITY, 8'hA5);
		send_frame(FR_BAD_FOOTER, 8'h3C);
		send_frame(FR_SHORT, -1);
		send_frame(FR_MID_GAP, -1);
		settle();

		configure(8'h00, 8'hFF, 8'd1, 8'd0);
		random_frames(1);
		settle();

		// zero gap: every byte restarts header search
		configure(8'($urandom), 8'($urandom), 8'd0, 8'($urandom));
		random_frames(1);
		settle();

		configure(8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)), 8'($urandom));
		random_frames(2);
		settle();

		quiet = 1'b1;
		configure(8'($urandom), 8'($urandom), 8'($urandom_range(1, 4)), 8'($urandom_range(0, 18)));
		send_frame(FR_GOOD, -1);
		send_frame(FR_GOOD, -1);
		settle();

		if (failures == 0 && waiting == 0)
			$display("sbus_frame_decoder_test OK");
		else
			$display("sbus_frame_decoder_test NOT OK");
		$finish;
	end

endmodule
